FILE: rtl/core/i2p_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_pkg: shared definitions for the infix to postfix converter
// Token and item codes, operator precedence, stack sizing and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package i2p_pkg;

    localparam int STACK_DEPTH = 16;
    localparam int MAX_RESULTS = 16;

    localparam int CNT_W  = $clog2(STACK_DEPTH + 1);
    localparam int PTR_W  = $clog2(STACK_DEPTH);
    localparam int RES_W  = $clog2(MAX_RESULTS + 1);
    localparam int KIND_W = 3;
    localparam int OPC_W  = 4;
    localparam int SLOT_W = 16;
    localparam int PREC_W = 4;

    // Group marker kept on the operator stack for an open parenthesis.
    localparam logic [OPC_W-1:0] MARKER = 4'hF;

    localparam logic [PREC_W-1:0] PREC_MUL = 4'd8;
    localparam logic [PREC_W-1:0] PREC_ADD = 4'd7;
    localparam logic [PREC_W-1:0] PREC_CMP = 4'd6;
    localparam logic [PREC_W-1:0] PREC_AND = 4'd5;
    localparam logic [PREC_W-1:0] PREC_OR  = 4'd4;

    typedef enum logic [KIND_W-1:0] {
        TOK_OPERAND  = 3'd0,
        TOK_OPERATOR = 3'd1,
        TOK_OPEN     = 3'd2,
        TOK_CLOSE    = 3'd3,
        TOK_END      = 3'd4
    } t_tok_kind;

    typedef enum logic [OPC_W-1:0] {
        OPC_ADD = 4'd0,
        OPC_SUB = 4'd1,
        OPC_MUL = 4'd2,
        OPC_DIV = 4'd3,
        OPC_MOD = 4'd4,
        OPC_EQ  = 4'd5,
        OPC_NE  = 4'd6,
        OPC_LT  = 4'd7,
        OPC_GE  = 4'd8,
        OPC_LE  = 4'd9,
        OPC_GT  = 4'd10,
        OPC_AND = 4'd11,
        OPC_OR  = 4'd12
    } t_opcode;

    localparam logic [OPC_W-1:0] NUM_OPS = 4'd13;

    typedef enum logic [1:0] {
        ITEM_PUSH = 2'd0,
        ITEM_OPER = 2'd1,
        ITEM_END  = 2'd2,
        ITEM_ERR  = 2'd3
    } t_item_kind;

    typedef enum logic [1:0] {
        ERR_NONE      = 2'd0,
        ERR_CONSEC    = 2'd1,
        ERR_OVERFLOW  = 2'd2,
        ERR_UNMATCHED = 2'd3
    } t_err_code;

    typedef enum logic {
        ST_IDLE = 1'b0,
        ST_PROC = 1'b1
    } t_state;

    typedef struct packed {
        t_item_kind        kind;
        logic [OPC_W-1:0]  opcode;
        logic [SLOT_W-1:0] slot;
        t_err_code         err;
        logic              last;
    } t_item;

    typedef struct packed {
        logic       accept;      // latch the input token
        logic       flush;       // send the held item out as the final one
        logic       produce;     // create a new result item
        t_item_kind prod_kind;
        t_err_code  prod_err;
        logic       push_code;   // push the token's operator
        logic       push_marker; // push a group marker
        logic       pop;
        logic       clear;       // empty the stack and drop the operator flag
        logic       set_prev;
        logic       clr_prev;
    } t_dp_cmd;

    typedef struct packed {
        logic [KIND_W-1:0] tok_kind;
        logic              code_ok;
        logic              prev;
        logic              cnt_zero;
        logic              cnt_full;
        logic              top_marker;
        logic              top_binds;  // top operator pops before the token's operator
        logic              mark_nz;
        logic              oper_cap;
        logic              pend_valid;
        logic              out_free;
    } t_dp_stat;

    function automatic logic [PREC_W-1:0] prec_of(input logic [OPC_W-1:0] code);
        logic [PREC_W-1:0] p;
        unique case (code)
            OPC_MUL, OPC_DIV, OPC_MOD:                      p = PREC_MUL;
            OPC_ADD, OPC_SUB:                               p = PREC_ADD;
            OPC_EQ, OPC_NE, OPC_LT, OPC_GE, OPC_LE, OPC_GT: p = PREC_CMP;
            OPC_AND:                                        p = PREC_AND;
            OPC_OR:                                         p = PREC_OR;
            default:                                        p = '0;
        endcase
        return p;
    endfunction

endpackage

FILE: rtl/core/i2p_ifs.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ifs: token and result channels
// Valid/ready channels carrying infix tokens in and postfix items out.
// ----------------------------------------------------------------------------
interface i2p_tok_if
    import i2p_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [KIND_W-1:0] op;
    logic [OPC_W-1:0]  operator_code;
    logic [SLOT_W-1:0] operand_slot;

    modport source (output valid, output op, output operator_code, output operand_slot,
                    input ready);
    modport sink (input valid, input op, input operator_code, input operand_slot,
                  output ready);
endinterface

interface i2p_item_if
    import i2p_pkg::*;
;
    logic              valid;
    logic              ready;
    logic [1:0]        item_kind;
    logic [OPC_W-1:0]  opcode;
    logic [SLOT_W-1:0] push_slot;
    logic [1:0]        error_code;
    logic              last;

    modport source (output valid, output item_kind, output opcode, output push_slot,
                    output error_code, output last, input ready);
    modport sink (input valid, input item_kind, input opcode, input push_slot,
                  input error_code, input last, output ready);
endinterface

FILE: rtl/core/infix_to_postfix_converter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter: shunting-yard infix to postfix conversion
// Takes infix tokens (operands, 13 left-associative binary operators at five
// precedence levels, parentheses and an end token) and returns postfix beats:
// operand pushes, operators, an end item, or an error item for consecutive
// operators, a stack overflow or an unmatched close, after which the operator
// stack is cleared. The last beat caused by a token carries last. One token is
// handled at a time. An operator pops each stacked operator that binds at least
// as tightly, a close pops the operators above its marker, and the end token
// empties the stack. While the result port is not stalled, the stack gives
// up one entry per cycle; the controller creates at most one result per
// cycle. The stack holds STACK_DEPTH entries, markers included.
// ----------------------------------------------------------------------------
module infix_to_postfix_converter
    import i2p_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    i2p_tok_if.sink     i_tok,
    i2p_item_if.source  o_item
);

    t_dp_cmd  w_cmd;
    t_dp_stat w_stat;
    logic     w_in_ready;
    logic     w_out_valid;
    t_item    w_out_item;

    i2p_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_tok.valid),
        .i_stat     (w_stat),
        .o_in_ready (w_in_ready),
        .o_cmd      (w_cmd)
    );

    i2p_dpath u_dpath (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_tok_op    (i_tok.op),
        .i_tok_code  (i_tok.operator_code),
        .i_tok_slot  (i_tok.operand_slot),
        .i_out_ready (o_item.ready),
        .o_stat      (w_stat),
        .o_out_valid (w_out_valid),
        .o_out_item  (w_out_item)
    );

    assign i_tok.ready       = w_in_ready;
    assign o_item.valid      = w_out_valid;
    assign o_item.item_kind  = w_out_item.kind;
    assign o_item.opcode     = w_out_item.opcode;
    assign o_item.push_slot  = w_out_item.slot;
    assign o_item.error_code = w_out_item.err;
    assign o_item.last       = w_out_item.last;

endmodule

FILE: rtl/core/i2p_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_ctrl: converter controller
// Sequences one token at a time: accepts it, then steps the stack datapath at most
// one pop and one result per cycle while the result port is free until it resolves.
// ----------------------------------------------------------------------------
module i2p_ctrl
    import i2p_pkg::*;
(
    input  logic     i_clk,
    input  logic     i_rst_n,
    input  logic     i_in_valid,
    input  t_dp_stat i_stat,
    output logic     o_in_ready,
    output t_dp_cmd  o_cmd
);

    t_state r_state;
    t_state n_state;
    logic   w_in_ready;
    logic   w_stay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Ready decode, shared by the next-state and output logic, and stay decode.
    always_comb begin
        w_in_ready = (r_state == ST_IDLE) && (!i_stat.pend_valid || i_stat.out_free);
        unique case (i_stat.tok_kind)
            TOK_OPERATOR: w_stay = i_stat.code_ok && !i_stat.prev && i_stat.top_binds;
            TOK_CLOSE:    w_stay = i_stat.mark_nz && !i_stat.top_marker;
            TOK_END:      w_stay = !i_stat.cnt_zero;
            default:      w_stay = 1'b0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_IDLE: begin
                if (i_in_valid && w_in_ready) begin
                    n_state = ST_PROC;
                end
            end
            ST_PROC: begin
                if (i_stat.out_free && !w_stay) begin
                    n_state = ST_IDLE;
                end
            end
            default: n_state = ST_IDLE;
        endcase
    end

    always_comb begin
        o_cmd           = '0;
        o_cmd.prod_kind = ITEM_PUSH;
        o_cmd.prod_err  = ERR_NONE;
        o_in_ready      = w_in_ready;
        unique case (r_state)
            ST_IDLE: begin
                o_cmd.accept = i_in_valid && w_in_ready;
                o_cmd.flush  = i_stat.pend_valid && i_stat.out_free;
            end
            ST_PROC: begin
                if (i_stat.out_free) begin
                    unique case (i_stat.tok_kind)
                        TOK_OPERAND: begin
                            o_cmd.produce  = 1'b1;
                            o_cmd.clr_prev = 1'b1;
                        end
                        TOK_OPERATOR: begin
                            if (!i_stat.code_ok) begin
                                o_cmd.produce = 1'b0;
                            end else if (i_stat.prev) begin
                                o_cmd.produce   = 1'b1;
                                o_cmd.prod_kind = ITEM_ERR;
                                o_cmd.prod_err  = ERR_CONSEC;
                                o_cmd.clear     = 1'b1;
                            end else if (i_stat.top_binds) begin
                                o_cmd.produce   = 1'b1;
                                o_cmd.prod_kind = ITEM_OPER;
                                o_cmd.pop       = 1'b1;
                            end else if (i_stat.cnt_full) begin
                                o_cmd.produce   = 1'b1;
                                o_cmd.prod_kind = ITEM_ERR;
                                o_cmd.prod_err  = ERR_OVERFLOW;
                                o_cmd.clear     = 1'b1;
                            end else begin
                                o_cmd.push_code = 1'b1;
                                o_cmd.set_prev  = 1'b1;
                            end
                        end
                        TOK_OPEN: begin
                            if (i_stat.cnt_full) begin
                                o_cmd.produce   = 1'b1;
                                o_cmd.prod_kind = ITEM_ERR;
                                o_cmd.prod_err  = ERR_OVERFLOW;
                                o_cmd.clear     = 1'b1;
                            end else begin
                                o_cmd.push_marker = 1'b1;
                                o_cmd.clr_prev    = 1'b1;
                            end
                        end
                        TOK_CLOSE: begin
                            if (!i_stat.mark_nz) begin
                                o_cmd.produce   = 1'b1;
                                o_cmd.prod_kind = ITEM_ERR;
                                o_cmd.prod_err  = ERR_UNMATCHED;
                                o_cmd.clear     = 1'b1;
                            end else begin
                                // The group's own marker is removed without a result.
                                o_cmd.pop       = 1'b1;
                                o_cmd.produce   = !i_stat.top_marker;
                                o_cmd.prod_kind = ITEM_OPER;
                                o_cmd.clr_prev  = i_stat.top_marker;
                            end
                        end
                        TOK_END: begin
                            if (!i_stat.cnt_zero) begin
                                // Markers of unclosed groups drop silently; one slot
                                // stays reserved for the end item.
                                o_cmd.pop       = 1'b1;
                                o_cmd.produce   = !i_stat.top_marker && !i_stat.oper_cap;
                                o_cmd.prod_kind = ITEM_OPER;
                            end else begin
                                o_cmd.produce   = 1'b1;
                                o_cmd.prod_kind = ITEM_END;
                                o_cmd.clear     = 1'b1;
                            end
                        end
                        default: o_cmd.produce = 1'b0;
                    endcase
                end
            end
            default: o_cmd.produce = 1'b0;
        endcase
    end

endmodule

FILE: rtl/core/i2p_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_dpath: converter datapath
// Token register, operator stack with group count, a one-item hold stage that
// lets the final result of a token be flagged, and the output register.
// ----------------------------------------------------------------------------
module i2p_dpath
    import i2p_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_dp_cmd           i_cmd,
    input  logic [KIND_W-1:0] i_tok_op,
    input  logic [OPC_W-1:0]  i_tok_code,
    input  logic [SLOT_W-1:0] i_tok_slot,
    input  logic              i_out_ready,
    output t_dp_stat          o_stat,
    output logic              o_out_valid,
    output t_item             o_out_item
);

    logic [KIND_W-1:0] r_tok_op;
    logic [OPC_W-1:0]  r_tok_code;
    logic [SLOT_W-1:0] r_tok_slot;

    logic [OPC_W-1:0]  r_stack [STACK_DEPTH];
    logic [CNT_W-1:0]  r_cnt;
    logic [CNT_W-1:0]  r_mark_cnt;
    logic              r_prev;
    logic [RES_W-1:0]  r_emit;

    t_item             r_pend;
    logic              r_pend_valid;
    t_item             r_out;
    logic              r_out_valid;

    logic [PTR_W-1:0]  w_top_idx;
    logic [OPC_W-1:0]  w_top;
    logic              w_top_marker;
    logic              w_out_free;
    t_item             w_new;
    t_item             w_pend_out;

    assign w_top_idx    = r_cnt[PTR_W-1:0] - PTR_W'(1);
    assign w_top        = r_stack[w_top_idx];
    assign w_top_marker = (w_top == MARKER);
    assign w_out_free   = !r_out_valid || i_out_ready;

    always_comb begin
        w_new        = '0;
        w_new.kind   = i_cmd.prod_kind;
        w_new.err    = i_cmd.prod_err;
        w_new.opcode = (i_cmd.prod_kind == ITEM_OPER) ? w_top : '0;
        w_new.slot   = (i_cmd.prod_kind == ITEM_PUSH) ? r_tok_slot : '0;
    end

    // A held item moves out as final on a flush, and as non-final when a
    // newer result of the same token displaces it.
    always_comb begin
        w_pend_out      = r_pend;
        w_pend_out.last = i_cmd.flush;
    end

    always_comb begin
        o_stat            = '0;
        o_stat.tok_kind   = r_tok_op;
        o_stat.code_ok    = (r_tok_code < NUM_OPS);
        o_stat.prev       = r_prev;
        o_stat.cnt_zero   = (r_cnt == '0);
        o_stat.cnt_full   = (r_cnt == CNT_W'(STACK_DEPTH));
        o_stat.top_marker = w_top_marker;
        o_stat.top_binds  = (r_cnt != '0) && !w_top_marker
                            && (prec_of(w_top) >= prec_of(r_tok_code));
        o_stat.mark_nz    = (r_mark_cnt != '0);
        o_stat.oper_cap   = (r_emit >= RES_W'(MAX_RESULTS - 1));
        o_stat.pend_valid = r_pend_valid;
        o_stat.out_free   = w_out_free;
    end

    // Control state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt        <= '0;
            r_mark_cnt   <= '0;
            r_prev       <= 1'b0;
            r_emit       <= '0;
            r_pend_valid <= 1'b0;
            r_out_valid  <= 1'b0;
        end else begin
            if (i_cmd.clear) begin
                r_cnt      <= '0;
                r_mark_cnt <= '0;
            end else begin
                if (i_cmd.push_code || i_cmd.push_marker) begin
                    r_cnt <= r_cnt + CNT_W'(1);
                end else if (i_cmd.pop) begin
                    r_cnt <= r_cnt - CNT_W'(1);
                end
                if (i_cmd.push_marker) begin
                    r_mark_cnt <= r_mark_cnt + CNT_W'(1);
                end else if (i_cmd.pop && w_top_marker) begin
                    r_mark_cnt <= r_mark_cnt - CNT_W'(1);
                end
            end

            if (i_cmd.clear || i_cmd.clr_prev) begin
                r_prev <= 1'b0;
            end else if (i_cmd.set_prev) begin
                r_prev <= 1'b1;
            end

            if (i_cmd.accept) begin
                r_emit <= '0;
            end else if (i_cmd.produce) begin
                r_emit <= r_emit + RES_W'(1);
            end

            if (i_cmd.flush) begin
                r_out_valid  <= 1'b1;
                r_pend_valid <= 1'b0;
            end else if (i_cmd.produce) begin
                r_pend_valid <= 1'b1;
                if (r_pend_valid) begin
                    r_out_valid <= 1'b1;
                end else if (i_out_ready) begin
                    r_out_valid <= 1'b0;
                end
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        if (i_cmd.accept) begin
            r_tok_op   <= i_tok_op;
            r_tok_code <= i_tok_code;
            r_tok_slot <= i_tok_slot;
        end
        if (i_cmd.push_code) begin
            r_stack[r_cnt[PTR_W-1:0]] <= r_tok_code;
        end else if (i_cmd.push_marker) begin
            r_stack[r_cnt[PTR_W-1:0]] <= MARKER;
        end
        if (i_cmd.flush) begin
            r_out <= w_pend_out;
        end else if (i_cmd.produce) begin
            r_pend <= w_new;
            if (r_pend_valid) begin
                r_out <= w_pend_out;
            end
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_item  = r_out;

endmodule

FILE: rtl/core/i2p_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2p_checker: port-level checks for the converter
// Watches the token and result channels of the top level.
// ----------------------------------------------------------------------------
module i2p_checker
    import i2p_pkg::*;
(
    input logic              i_clk,
    input logic              i_rst_n,
    input logic              i_in_valid,
    input logic              i_in_ready,
    input logic              i_out_valid,
    input logic              i_out_ready,
    input logic [1:0]        i_item_kind,
    input logic [OPC_W-1:0]  i_opcode,
    input logic [SLOT_W-1:0] i_push_slot,
    input logic [1:0]        i_error_code,
    input logic              i_last
);

    // Tokens are handled one at a time, so an accept is never followed at once
    // by another.
    a_one_token: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_in_valid && i_in_ready |=> !i_in_ready)
        else $error("token accepted while the previous one is still in work");

    // An error ends the token's results.
    a_err_last: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_item_kind == ITEM_ERR) |-> i_last && (i_error_code != ERR_NONE))
        else $error("error beat without last or without a code");

    // Operator beats carry only their opcode.
    a_oper_clean: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_item_kind == ITEM_OPER)
        |-> (i_push_slot == '0) && (i_error_code == ERR_NONE) && (i_opcode < NUM_OPS))
        else $error("operator beat with stray fields");

    a_reset_quiet: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result valid right after reset");

    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid
        && $stable({i_item_kind, i_opcode, i_push_slot, i_error_code, i_last}))
        else $error("stalled result beat changed");

endmodule

bind infix_to_postfix_converter i2p_checker u_i2p_checker (
    .i_clk        (i_clk),
    .i_rst_n      (i_rst_n),
    .i_in_valid   (i_tok.valid),
    .i_in_ready   (i_tok.ready),
    .i_out_valid  (o_item.valid),
    .i_out_ready  (o_item.ready),
    .i_item_kind  (o_item.item_kind),
    .i_opcode     (o_item.opcode),
    .i_push_slot  (o_item.push_slot),
    .i_error_code (o_item.error_code),
    .i_last       (o_item.last)
);

FILE: verif/infix_to_postfix_converter_tb.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// infix_to_postfix_converter_tb: self-checking bench for the shunting-yard block
// Feeds infix tokens into the token channel and checks every postfix beat
// against a predictor that tracks the operator stack. A directed opening covers
// token kinds, field extremes and error cases. Random well-formed expressions,
// deep nesting and noise follow, under several idle and stall settings.
// ----------------------------------------------------------------------------
import i2p_pkg::*;

class postfix_ledger;

    logic [OPC_W-1:0] op_stack [STACK_DEPTH];
    int               stack_fill;
    bit               after_operator;
    t_item            batch [$];
    t_item            pending_items [$];
    int               mismatches;

    function logic [PREC_W-1:0] level_of(logic [OPC_W-1:0] code);
        if (code == OPC_OR) return PREC_OR;
        if (code == OPC_AND) return PREC_AND;
        if (code >= OPC_EQ && code <= OPC_GT) return PREC_CMP;
        if (code >= OPC_MUL && code <= OPC_MOD) return PREC_MUL;
        return PREC_ADD;
    endfunction

    function void clear_stack();
        stack_fill = 0;
        after_operator = 1'b0;
    endfunction

    function void add_result(int cap, t_item_kind kind, logic [OPC_W-1:0] opcode,
                             logic [SLOT_W-1:0] slot, t_err_code err);
        t_item r;
        if (batch.size() >= cap || batch.size() >= MAX_RESULTS) return;
        r.kind   = kind;
        r.opcode = opcode;
        r.slot   = slot;
        r.err    = err;
        r.last   = 1'b0;
        batch.push_back(r);
    endfunction

    // Works out the beats caused by one accepted token.
    function void take_token(logic [KIND_W-1:0] kind, logic [OPC_W-1:0] code,
                             logic [SLOT_W-1:0] slot);
        logic [OPC_W-1:0] top;
        bit               found;
        batch.delete();
        case (kind)
            TOK_OPERAND: begin
                add_result(MAX_RESULTS, ITEM_PUSH, '0, slot, ERR_NONE);
                after_operator = 1'b0;
            end
            TOK_OPERATOR: begin
                if (code < NUM_OPS) begin
                    if (after_operator) begin
                        add_result(MAX_RESULTS, ITEM_ERR, '0, '0, ERR_CONSEC);
                        clear_stack();
                    end else begin
                        while (stack_fill > 0 && op_stack[stack_fill-1] != MARKER &&
                               level_of(op_stack[stack_fill-1]) >= level_of(code)) begin
                            add_result(MAX_RESULTS, ITEM_OPER, op_stack[stack_fill-1], '0,
                                       ERR_NONE);
                            stack_fill--;
                        end
                        if (stack_fill >= STACK_DEPTH) begin
                            add_result(MAX_RESULTS, ITEM_ERR, '0, '0, ERR_OVERFLOW);
                            clear_stack();
                        end else begin
                            op_stack[stack_fill] = code;
                            stack_fill++;
                            after_operator = 1'b1;
                        end
                    end
                end
            end
            TOK_OPEN: begin
                if (stack_fill >= STACK_DEPTH) begin
                    add_result(MAX_RESULTS, ITEM_ERR, '0, '0, ERR_OVERFLOW);
                    clear_stack();
                end else begin
                    op_stack[stack_fill] = MARKER;
                    stack_fill++;
                    after_operator = 1'b0;
                end
            end
            TOK_CLOSE: begin
                found = 1'b0;
                for (int i = 0; i < stack_fill; i++)
                    if (op_stack[i] == MARKER) found = 1'b1;
                if (!found) begin
                    add_result(MAX_RESULTS, ITEM_ERR, '0, '0, ERR_UNMATCHED);
                    clear_stack();
                end else begin
                    // A marker is known to exist, so this stops at it.
                    top = '0;
                    while (top != MARKER) begin
                        stack_fill--;
                        top = op_stack[stack_fill];
                        if (top != MARKER)
                            add_result(MAX_RESULTS, ITEM_OPER, top, '0, ERR_NONE);
                    end
                    after_operator = 1'b0;
                end
            end
            TOK_END: begin
                // One slot is kept free so that the end item always fits.
                while (stack_fill > 0) begin
                    stack_fill--;
                    top = op_stack[stack_fill];
                    if (top != MARKER)
                        add_result(MAX_RESULTS - 1, ITEM_OPER, top, '0, ERR_NONE);
                end
                add_result(MAX_RESULTS, ITEM_END, '0, '0, ERR_NONE);
                clear_stack();
            end
            default: ;
        endcase
        if (batch.size() > 0) batch[batch.size()-1].last = 1'b1;
        foreach (batch[i]) pending_items.push_back(batch[i]);
    endfunction

    function void compare_field(string name, logic [SLOT_W-1:0] want,
                                logic [SLOT_W-1:0] got);
        if (got !== want) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    function void check_beat(logic [1:0] kind, logic [OPC_W-1:0] opcode,
                             logic [SLOT_W-1:0] slot, logic [1:0] err, logic last);
        t_item want;
        if (pending_items.size() == 0) begin
            $error("unexpected beat: item_kind %0d opcode %0d push_slot %0d error_code %0d",
                   kind, opcode, slot, err);
            mismatches++;
            return;
        end
        want = pending_items.pop_front();
        compare_field("item_kind", SLOT_W'(want.kind), SLOT_W'(kind));
        compare_field("opcode", SLOT_W'(want.opcode), SLOT_W'(opcode));
        compare_field("push_slot", want.slot, slot);
        compare_field("error_code", SLOT_W'(want.err), SLOT_W'(err));
        compare_field("last", SLOT_W'(want.last), SLOT_W'(last));
    endfunction

    function int outstanding();
        return pending_items.size();
    endfunction

endclass

module infix_to_postfix_converter_tb;

    localparam int CYCLE_LIMIT  = 400000;
    localparam int HOLD_CYCLES  = 300;
    localparam int RANDOM_ITEMS = 460;
    localparam int SETTLE_WAIT  = 40;

    localparam logic [KIND_W-1:0] TOK_BAD_LO = 3'd5;
    localparam logic [KIND_W-1:0] TOK_BAD_HI = 3'd7;
    localparam logic [OPC_W-1:0]  OPC_BAD_LO = 4'd13;
    localparam logic [OPC_W-1:0]  OPC_BAD_HI = 4'd15;

    logic i_clk = 1'b0;
    logic i_rst_n;

    i2p_tok_if  tok_bus ();
    i2p_item_if item_bus ();

    infix_to_postfix_converter dut (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_tok   (tok_bus),
        .o_item  (item_bus)
    );

    postfix_ledger ledger = new;

    int          tx_idle_pct;
    int          rx_stall_pct;
    int          hold_reqs;
    int          hold_seen;
    int          hold_left;
    int          token_count;
    int unsigned cycle_count;

    always begin
        #1 i_clk = 1'b1;
        #1 i_clk = 1'b0;
    end

    // Offers one token and waits until the token channel takes it.
    task automatic send_token(input logic [KIND_W-1:0] kind, input logic [OPC_W-1:0] code,
                              input logic [SLOT_W-1:0] slot);
        while ($urandom_range(99) < tx_idle_pct) begin
            tok_bus.valid <= 1'b0;
            @(posedge i_clk);
        end
        tok_bus.valid         <= 1'b1;
        tok_bus.op            <= kind;
        tok_bus.operator_code <= code;
        tok_bus.operand_slot  <= slot;
        @(posedge i_clk);
        while (tok_bus.ready !== 1'b1) @(posedge i_clk);
        ledger.take_token(kind, code, slot);
        if (kind <= TOK_END && (kind != TOK_OPERATOR || code < NUM_OPS)) token_count++;
    endtask

    task automatic send_noise();
        send_token(KIND_W'($urandom_range(7)), OPC_W'($urandom_range(15)),
                   SLOT_W'($urandom_range(65535)));
    endtask

    // A well-formed expression with random operands, operators and groups,
    // now and then broken up by a random token.
    task automatic send_expression();
        int depth;
        int terms;
        bit want_operand;
        depth = 0;
        want_operand = 1'b1;
        terms = $urandom_range(1, 12);
        for (int i = 0; i < terms; i++) begin
            if ($urandom_range(19) == 0) send_noise();
            if (want_operand) begin
                if (depth < 4 && $urandom_range(3) == 0) begin
                    send_token(TOK_OPEN, OPC_W'($urandom_range(15)),
                               SLOT_W'($urandom_range(65535)));
                    depth++;
                end else begin
                    send_token(TOK_OPERAND, OPC_W'($urandom_range(15)),
                               SLOT_W'($urandom_range(65535)));
                    want_operand = 1'b0;
                end
            end else if (depth > 0 && $urandom_range(2) == 0) begin
                send_token(TOK_CLOSE, OPC_W'($urandom_range(15)),
                           SLOT_W'($urandom_range(65535)));
                depth--;
            end else begin
                send_token(TOK_OPERATOR, OPC_W'($urandom_range(12)),
                           SLOT_W'($urandom_range(65535)));
                want_operand = 1'b1;
            end
        end
        if (want_operand)
            send_token(TOK_OPERAND, OPC_W'($urandom_range(15)),
                       SLOT_W'($urandom_range(65535)));
        while (depth > 0 && $urandom_range(4) != 0) begin
            send_token(TOK_CLOSE, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
            depth--;
        end
        send_token(TOK_END, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
    endtask

    // Nests close to or past the stack depth so that both overflow paths fire.
    task automatic send_deep_nest();
        repeat ($urandom_range(13, 17))
            send_token(TOK_OPEN, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
        if ($urandom_range(1) == 0)
            send_token(TOK_OPERATOR, OPC_W'($urandom_range(12)),
                       SLOT_W'($urandom_range(65535)));
        send_token(TOK_OPERAND, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
        send_token(TOK_OPERATOR, OPC_ADD, SLOT_W'($urandom_range(65535)));
        send_token(TOK_OPERAND, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
        send_token(TOK_OPERATOR, OPC_MUL, SLOT_W'($urandom_range(65535)));
        send_token(TOK_OPERAND, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
        send_token(TOK_END, OPC_W'($urandom_range(15)), SLOT_W'($urandom_range(65535)));
    endtask

    task automatic send_random_chunk();
        int pick;
        pick = $urandom_range(15);
        if (pick == 0) send_deep_nest();
        else if (pick == 1) repeat ($urandom_range(1, 4)) send_noise();
        else send_expression();
    endtask

    task automatic wait_drain();
        tok_bus.valid <= 1'b0;
        while (ledger.outstanding() != 0) @(posedge i_clk);
    endtask

    // Result side: checks each beat and drives ready, with an optional long hold.
    initial begin
        item_bus.ready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (i_rst_n === 1'b1 && item_bus.valid === 1'b1 && item_bus.ready === 1'b1)
                ledger.check_beat(item_bus.item_kind, item_bus.opcode, item_bus.push_slot,
                                  item_bus.error_code, item_bus.last);
            if (hold_reqs != hold_seen) begin
                hold_seen = hold_reqs;
                hold_left = HOLD_CYCLES;
            end
            if (hold_left > 0) begin
                hold_left--;
                item_bus.ready <= 1'b0;
            end else begin
                item_bus.ready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    initial begin
        cycle_count = 0;
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("[infix_to_postfix_converter] ERROR");
        $finish;
    end

    initial begin
        int random_start;
        tok_bus.valid         <= 1'b0;
        tok_bus.op            <= TOK_OPERAND;
        tok_bus.operator_code <= OPC_ADD;
        tok_bus.operand_slot  <= '0;
        i_rst_n               <= 1'b0;
        tx_idle_pct  = 0;
        rx_stall_pct = 0;
        hold_reqs    = 0;
        hold_seen    = 0;
        hold_left    = 0;
        token_count  = 0;
        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Leading operator, nested group, pops across precedence levels.
        send_token(TOK_OPERATOR, OPC_ADD, 16'h0000);
        send_token(TOK_OPERAND, OPC_ADD, 16'h0000);
        send_token(TOK_OPERATOR, OPC_MUL, 16'hFFFF);
        send_token(TOK_OPEN, OPC_BAD_HI, 16'hFFFF);
        send_token(TOK_OPERAND, OPC_BAD_HI, 16'hFFFF);
        send_token(TOK_OPERATOR, OPC_SUB, 16'h0000);
        send_token(TOK_OPERAND, OPC_ADD, 16'h1234);
        send_token(TOK_CLOSE, OPC_ADD, 16'h0000);
        send_token(TOK_OPERATOR, OPC_OR, 16'h0000);
        send_token(TOK_OPERAND, OPC_ADD, 16'h0007);
        send_token(TOK_END, OPC_ADD, 16'h0000);
        // Empty group stands for an operand; then the error cases.
        send_token(TOK_OPEN, OPC_ADD, 16'h0000);
        send_token(TOK_CLOSE, OPC_ADD, 16'h0000);
        send_token(TOK_OPERATOR, OPC_AND, 16'h0000);
        send_token(TOK_OPERATOR, OPC_EQ, 16'h0000);
        send_token(TOK_CLOSE, OPC_ADD, 16'h0000);
        // Tokens that the block drops.
        send_token(TOK_BAD_LO, OPC_LT, 16'hAAAA);
        send_token(TOK_BAD_HI, OPC_BAD_HI, 16'h5555);
        send_token(TOK_OPERATOR, OPC_BAD_LO, 16'h0000);
        send_token(TOK_OPERATOR, OPC_BAD_HI, 16'h0000);
        // Unclosed groups vanish at the end token.
        send_token(TOK_OPEN, OPC_ADD, 16'h0000);
        send_token(TOK_OPERAND, OPC_ADD, 16'h0005);
        send_token(TOK_OPERATOR, OPC_GT, 16'h0000);
        send_token(TOK_OPEN, OPC_ADD, 16'h0000);
        send_token(TOK_END, OPC_ADD, 16'h0000);
        wait_drain();

        random_start = token_count;
        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
                1: begin tx_idle_pct = 50; rx_stall_pct = 0;  end
                2: begin tx_idle_pct = 0;  rx_stall_pct = 50; end
                default: begin tx_idle_pct = 20; rx_stall_pct = 20; end
            endcase
            // The sender keeps offering tokens while the result side holds off.
            if (phase == 0) hold_reqs++;
            while (token_count < random_start + (phase + 1) * RANDOM_ITEMS / 4)
                send_random_chunk();
            wait_drain();
        end

        repeat (SETTLE_WAIT) @(posedge i_clk);
        if (ledger.mismatches == 0 && ledger.outstanding() == 0) begin
            $display("[infix_to_postfix_converter] OK");
        end else begin
            $display("[infix_to_postfix_converter] ERROR");
        end
        $finish;
    end

endmodule
